### design/xxe_pkg.sv
// Shared command codes, register indexes, widths and reset values for the echo engine.
`default_nettype none

package xxe_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int HOLD_W     = 16;
  localparam int IDLE_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_RX_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TX_PULL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_XON_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_HOLD  = 2'd2;

  localparam logic [BYTE_W-1:0] XON_RESET      = 8'h11;
  localparam logic [BYTE_W-1:0] XOFF_RESET     = 8'h13;
  localparam logic [HOLD_W-1:0] LED_HOLD_RESET = 16'd200;
  localparam logic [IDLE_W-1:0] IDLE_MAX       = '1;

  // Statistics counters that travel together down the result pipeline.
  typedef struct packed {
    logic [CNT_W-1:0] rx;
    logic [CNT_W-1:0] tx;
    logic [CNT_W-1:0] echo_rx;
    logic [CNT_W-1:0] echo_tx;
    logic [CNT_W-1:0] echo_drop;
  } stats_t;

endpackage

`default_nettype wire

### design/xxe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module xxe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds until the next read is issued.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/xon_xoff_echo_fifo_with_stats_core.sv
// XON/XOFF echo engine: mode control, byte FIFO in RAM, statistics and activity LED.
// Result path: an accepted item moves through stage A into the stage B output register,
// where out_valid rises. Throughput: one item per cycle while in_stall is low; the FIFO RAM
// takes at most one push or one pop per item, and its registered read data joins the result.
// Reset (rst, synchronous): report mode, FIFO empty, counters zero, LED off and
// registers back to XON 0x11, XOFF 0x13 and a hold time of 200 ticks.
`default_nettype none

module xon_xoff_echo_fifo_with_stats_core
  import xxe_pkg::*;
#(
  parameter int FIFO_DEPTH = 128,
  localparam int PTR_W = $clog2(FIFO_DEPTH),
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input item channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  // Result item channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       tx_valid,
  output logic      [BYTE_W-1:0]     tx_byte,
  output logic                       echo_mode,
  output logic                       led_on,
  output logic      [CNT_W-1:0]      rx_count,
  output logic      [CNT_W-1:0]      tx_count,
  output logic      [CNT_W-1:0]      echo_rx_count,
  output logic      [CNT_W-1:0]      echo_tx_count,
  output logic      [CNT_W-1:0]      echo_drop_count,
  output logic      [LVL_W-1:0]      fifo_level,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] LEVEL_FULL = LVL_W'(FIFO_DEPTH);

  // Configuration registers. Writes are always taken.
  logic [BYTE_W-1:0] xon_code;
  logic [BYTE_W-1:0] xoff_code;
  logic [HOLD_W-1:0] led_hold_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      xon_code       <= XON_RESET;
      xoff_code      <= XOFF_RESET;
      led_hold_ticks <= LED_HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_XON_CODE:  xon_code       <= cfg_data[BYTE_W-1:0];
        REG_XOFF_CODE: xoff_code      <= cfg_data[BYTE_W-1:0];
        REG_LED_HOLD:  led_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Architectural state. The FIFO bytes themselves live in the RAM below.
  logic              mode;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [LVL_W-1:0]  fill;
  stats_t            stats;
  logic              led;
  logic [IDLE_W-1:0] idle;

  logic              mode_next;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [LVL_W-1:0]  fill_next;
  stats_t            stats_next;
  logic              led_next;
  logic [IDLE_W-1:0] idle_next;
  logic              push;
  logic              pop;

  // Pipeline: stage A waits for the RAM read, stage B is the output register.
  logic   a_valid;
  logic   a_pop;
  logic   a_mode;
  logic   a_led;
  stats_t a_stats;
  logic [LVL_W-1:0] a_level;
  logic   a_move;
  logic   in_take;
  logic   out_take;
  logic [BYTE_W-1:0] ram_rd_data;

  assign out_take = out_valid && !out_stall;
  assign a_move   = a_valid && (!out_valid || !out_stall);
  // Stall only when both stages are full and the output is held. While stalled no
  // new read is issued, so the RAM read data for stage A stays put.
  assign in_stall = a_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Next-state logic for one item; applied only when an item is taken.
  always_comb begin
    mode_next   = mode;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    stats_next  = stats;
    led_next    = led;
    idle_next   = idle;
    push        = 1'b0;
    pop         = 1'b0;

    case (command)
      CMD_RX_BYTE: begin
        if (mode) begin
          if (rx_byte == xoff_code) begin
            mode_next = 1'b0;
          end else if (fill != LEVEL_FULL) begin
            push               = 1'b1;
            wr_ptr_next        = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
            fill_next          = fill + 1'b1;
            stats_next.echo_rx = stats.echo_rx + 1'b1;
          end else begin
            stats_next.echo_drop = stats.echo_drop + 1'b1;
          end
        end else if (rx_byte == xon_code) begin
          mode_next = 1'b1;
        end
        stats_next.rx = stats.rx + 1'b1;
        led_next      = 1'b1;
        idle_next     = '0;
      end
      CMD_TX_PULL: begin
        if (mode && fill != '0) begin
          pop                = 1'b1;
          rd_ptr_next        = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
          fill_next          = fill - 1'b1;
          stats_next.echo_tx = stats.echo_tx + 1'b1;
          stats_next.tx      = stats.tx + 1'b1;
        end
      end
      CMD_TICK: begin
        if (idle != IDLE_MAX) begin
          idle_next = idle + 1'b1;
        end
        if (led && idle_next > {1'b0, led_hold_ticks}) begin
          led_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
      stats  <= '0;
      led    <= 1'b0;
      idle   <= '0;
    end else if (in_take) begin
      mode   <= mode_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
      stats  <= stats_next;
      led    <= led_next;
      idle   <= idle_next;
    end
  end

  // A push and a pop never come in the same cycle, and a pop only reads an entry
  // written by an earlier item, so no forwarding around the RAM is needed.
  xxe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (in_take && push),
    .wr_addr (wr_ptr),
    .wr_data (rx_byte),
    .rd_en   (in_take && pop),
    .rd_addr (rd_ptr),
    .rd_data (ram_rd_data)
  );

  // Stage A holds the state after the item while the pop read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_pop   <= pop;
      a_mode  <= mode_next;
      a_led   <= led_next;
      a_stats <= stats_next;
      a_level <= fill_next;
    end
  end

  // Stage B is the output register; the popped byte joins the result here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      tx_valid        <= a_pop;
      tx_byte         <= a_pop ? ram_rd_data : '0;
      echo_mode       <= a_mode;
      led_on          <= a_led;
      rx_count        <= a_stats.rx;
      tx_count        <= a_stats.tx;
      echo_rx_count   <= a_stats.echo_rx;
      echo_tx_count   <= a_stats.echo_tx;
      echo_drop_count <= a_stats.echo_drop;
      fifo_level      <= a_level;
    end
  end

  // The fill level never exceeds the FIFO depth.
  assert property (@(posedge clk) disable iff (rst) fill <= LEVEL_FULL)
    else $error("FIFO fill level above depth");

  // A pop is only issued on a non-empty FIFO in echo mode.
  assert property (@(posedge clk) disable iff (rst)
    (in_take && pop) |-> (mode && fill != '0))
    else $error("pop issued on empty FIFO or in report mode");

  // A push is never issued on a full FIFO.
  assert property (@(posedge clk) disable iff (rst)
    (in_take && push) |-> (fill != LEVEL_FULL))
    else $error("push issued on full FIFO");

  // Stage A that cannot move keeps its item, and its RAM read data holds.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_move) |=> (a_valid && $stable(ram_rd_data)))
    else $error("stage A lost its item or read data while blocked");

  // An empty FIFO has equal read and write pointers.
  assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty FIFO with unequal pointers");

endmodule

`default_nettype wire
